// ----- rtl/rose_pkg.sv -----
// Shared types and constants for the range order-statistics engine.
package rose_pkg;

    localparam int TYPE_W = 3;
    localparam int IDX_W  = 10;
    localparam int KEY_W  = 27;
    localparam int ANS_W  = 32;
    // search bounds reach VALUE_MAX + 1, one bit above a stored value
    localparam int SRCH_W = KEY_W + 1;

    localparam logic [ANS_W-1:0] NOT_FOUND_HIGH = 32'h7FFF_FFFF;
    localparam logic [ANS_W-1:0] NOT_FOUND_LOW  = 32'h8000_0001;

    typedef enum logic [TYPE_W-1:0] {
        REQ_RANK   = 3'd0,
        REQ_KTH    = 3'd1,
        REQ_UPDATE = 3'd2,
        REQ_PRED   = 3'd3,
        REQ_SUCC   = 3'd4
    } t_req_type;

    typedef struct packed {
        logic load;       // capture request fields and span
        logic wr_update;  // write the update value into the store
        logic clr_wr;     // clearing pass: zero one entry, advance pointer
        logic scan_init;  // pointer to span start, clear accumulators
        logic issue;      // read at pointer, advance pointer
        logic kinit;      // open the value search window
        logic set_mid;    // bound becomes the window midpoint
        logic kstep;      // narrow the window from the last count
        logic result;     // load the output register
    } t_cmd;

    typedef struct packed {
        logic in_update;
        logic in_query;
        logic empty;
        logic scan_last;
        logic clr_last;
        logic search_open;
        logic is_kth;
        logic out_busy;
    } t_sts;

endpackage

// ----- rtl/rose_if.sv -----
// Request and response channel interfaces.
interface rose_req_if import rose_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [IDX_W-1:0]  index_low;
    logic [IDX_W-1:0]  index_high;
    logic [KEY_W-1:0]  key;

    modport source(output valid, req_type, index_low, index_high, key, input ready);
    modport sink(input valid, req_type, index_low, index_high, key, output ready);
endinterface

interface rose_rsp_if import rose_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ANS_W-1:0] answer;

    modport source(output valid, answer, input ready);
    modport sink(input valid, answer, output ready);
endinterface

// ----- rtl/rose_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rose_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rose_ctrl.sv -----
// Sequencer for clearing, scans, value search and result hand-off.
module rose_ctrl import rose_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_KCHECK,
        ST_KSTEP,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.wr_update = i_sts.in_update;
                    o_cmd.load      = i_sts.in_query;
                    if (i_sts.in_query) n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (i_sts.is_kth) begin
                    o_cmd.kinit = 1'b1;
                    n_state     = ST_KCHECK;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = i_sts.empty ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = i_sts.is_kth ? ST_KSTEP : ST_FINISH;
            end
            ST_KCHECK: begin
                if (i_sts.search_open) begin
                    o_cmd.set_mid   = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    // empty span: count stays zero, no walk needed
                    n_state = i_sts.empty ? ST_KSTEP : ST_SCAN;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_KSTEP: begin
                o_cmd.kstep = 1'b1;
                n_state     = ST_KCHECK;
            end
            ST_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.result = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/rose_dp.sv -----
// Datapath: value store, scan pointer, accumulators, search window, output register.
module rose_dp import rose_pkg::*; #(
    parameter int ARRAY_DEPTH = 1024,
    parameter int VALUE_MAX   = 100000000
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [TYPE_W-1:0]       i_req_type,
    input  logic [IDX_W-1:0]        i_index_low,
    input  logic [IDX_W-1:0]        i_index_high,
    input  logic [KEY_W-1:0]        i_key,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [ANS_W-1:0] o_answer,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts
);

    localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
    localparam int CW = $clog2(ARRAY_DEPTH + 1);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(ARRAY_DEPTH - 1);
    localparam logic [SRCH_W-1:0] SRCH_TOP  = SRCH_W'(VALUE_MAX + 1);
    localparam logic [KEY_W-1:0]  SAT_VAL   = KEY_W'(VALUE_MAX);

    t_req_type               r_type;
    logic [KEY_W-1:0]        r_key;
    logic [SRCH_W-1:0]       r_bound;
    logic [AW-1:0]           r_span_lo;
    logic [AW-1:0]           r_span_hi;
    logic                    r_empty;
    logic [AW-1:0]           r_ptr;
    logic                    r_rd_valid;
    logic [CW-1:0]           r_count;
    logic [KEY_W-1:0]        r_best;
    logic                    r_found;
    logic [SRCH_W-1:0]       r_slo;
    logic [SRCH_W-1:0]       r_shi;
    logic                    r_out_valid;
    logic signed [ANS_W-1:0] r_answer;

    logic                    w_in_range;
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic [KEY_W-1:0]        w_wdata;
    logic [KEY_W-1:0]        w_sat;
    logic [KEY_W-1:0]        w_rdata;
    logic [SRCH_W-1:0]       w_rval;
    logic [SRCH_W:0]         w_sum;
    logic                    w_below;
    logic                    w_above;
    logic signed [ANS_W-1:0] w_answer;

    assign w_in_range = (32'(i_index_low) < ARRAY_DEPTH);
    assign w_sat      = (32'(i_key) > VALUE_MAX) ? SAT_VAL : i_key;
    assign w_we       = i_cmd.clr_wr || (i_cmd.wr_update && w_in_range);
    assign w_waddr    = i_cmd.clr_wr ? r_ptr : AW'(i_index_low);
    assign w_wdata    = i_cmd.clr_wr ? '0 : w_sat;

    rose_ram #(
        .WIDTH(KEY_W),
        .DEPTH(ARRAY_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_ptr),
        .o_rdata(w_rdata)
    );

    assign w_rval  = {1'b0, w_rdata};
    assign w_below = (w_rval < r_bound);
    assign w_above = (w_rval > r_bound);
    assign w_sum   = {1'b0, r_slo} + {1'b0, r_shi};

    always_comb begin
        case (r_type)
            REQ_RANK: w_answer = ANS_W'(r_count) + ANS_W'(1);
            REQ_KTH:  w_answer = ANS_W'(r_best);
            REQ_PRED: w_answer = r_found ? ANS_W'(r_best) : NOT_FOUND_LOW;
            default:  w_answer = r_found ? ANS_W'(r_best) : NOT_FOUND_HIGH;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr || i_cmd.issue) begin
                r_ptr <= r_ptr + AW'(1);
            end else if (i_cmd.scan_init) begin
                r_ptr <= r_span_lo;
            end
            r_rd_valid <= i_cmd.issue;
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type    <= t_req_type'(i_req_type);
            r_key     <= i_key;
            r_bound   <= {1'b0, i_key};
            r_empty   <= !w_in_range || (i_index_low > i_index_high);
            r_span_lo <= AW'(i_index_low);
            r_span_hi <= (32'(i_index_high) >= ARRAY_DEPTH) ? LAST_ADDR : AW'(i_index_high);
        end
        if (i_cmd.set_mid) begin
            r_bound <= w_sum[SRCH_W:1];
        end
        if (i_cmd.kinit) begin
            r_slo  <= '0;
            r_shi  <= SRCH_TOP;
            r_best <= '0;
        end
        if (i_cmd.kstep) begin
            if (32'(r_count) < 32'(r_key)) begin
                r_best <= r_bound[KEY_W-1:0];
                r_slo  <= r_bound + SRCH_W'(1);
            end else begin
                r_shi <= r_bound;
            end
        end
        if (i_cmd.scan_init) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else if (r_rd_valid) begin
            case (r_type)
                REQ_RANK, REQ_KTH: begin
                    if (w_below) r_count <= r_count + CW'(1);
                end
                REQ_PRED: begin
                    if (w_below && (!r_found || w_rdata > r_best)) begin
                        r_best  <= w_rdata;
                        r_found <= 1'b1;
                    end
                end
                default: begin
                    if (w_above && (!r_found || w_rdata < r_best)) begin
                        r_best  <= w_rdata;
                        r_found <= 1'b1;
                    end
                end
            endcase
        end
        if (i_cmd.result) begin
            r_answer <= w_answer;
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.in_update   = (i_req_type == REQ_UPDATE);
        o_sts.in_query    = (i_req_type == REQ_RANK) || (i_req_type == REQ_KTH)
                         || (i_req_type == REQ_PRED) || (i_req_type == REQ_SUCC);
        o_sts.empty       = r_empty;
        o_sts.scan_last   = (r_ptr == r_span_hi);
        o_sts.clr_last    = (r_ptr == LAST_ADDR);
        o_sts.search_open = (r_slo < r_shi);
        o_sts.is_kth      = (r_type == REQ_KTH);
        o_sts.out_busy    = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;

endmodule

// ----- rtl/range_order_statistics_engine_core.sv -----
// Top level of the range order-statistics engine.
//
//  channel | dir | fields                                   | request moves when
//  i_req   | in  | req_type, index_low, index_high, key     | valid && ready
//  o_rsp   | out | answer (signed 32)                       | valid && ready
//
// Update and unused request codes complete in the idle state as they are taken.
// Rank, predecessor and successor walk the span through the single store
// read port, reading each of its entries in turn. Kth runs a binary search
// over the value range, about log2(VALUE_MAX + 2) count walks of the span.
// After reset a clearing pass zeroes the store with i_req held not ready.
// A stalled o_rsp holds its answer; the next request is taken meanwhile
// and waits at its end for the output register.
module range_order_statistics_engine_core import rose_pkg::*; #(
    parameter int ARRAY_DEPTH = 1024,
    parameter int VALUE_MAX   = 100000000
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rose_req_if.sink   i_req,
    rose_rsp_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    rose_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(i_req.ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    rose_dp #(
        .ARRAY_DEPTH(ARRAY_DEPTH),
        .VALUE_MAX  (VALUE_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (i_req.req_type),
        .i_index_low (i_req.index_low),
        .i_index_high(i_req.index_high),
        .i_key       (i_req.key),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_answer    (o_rsp.answer),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule
